// ===== src/rbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_pkg
// Field widths, item kind codes and mapping constants shared by the
// rank brightness mapper files.
// ----------------------------------------------------------------------------
package rbm_pkg;

	localparam int KIND_W     = 2;
	localparam int PIX_W      = 12;
	localparam int BRI_W      = 8;
	localparam int WIDTH_BITS = 24;

	// brightness = BRI_BASE + remaining * BRI_SPAN / total
	localparam int BRI_BASE = 64;
	localparam int BRI_SPAN = 191;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;
	localparam logic [KIND_W-1:0] KIND_MAP    = 2'd3;

endpackage

// ===== src/rbm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm channel interfaces
// Valid/ready channels for sample items, result items and the width register.
// ----------------------------------------------------------------------------
interface rbm_sample_if;
	import rbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [PIX_W-1:0]  pixel_value;
	modport source (output valid, kind, pixel_value, input ready);
	modport sink   (input valid, kind, pixel_value, output ready);
endinterface

interface rbm_result_if;
	import rbm_pkg::*;
	logic             valid;
	logic             ready;
	logic [BRI_W-1:0] brightness;
	logic             status;
	modport source (output valid, brightness, status, input ready);
	modport sink   (input valid, brightness, status, output ready);
endinterface

interface rbm_cfg_if;
	import rbm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [WIDTH_BITS-1:0] image_width;
	modport source (output valid, image_width, input ready);
	modport sink   (input valid, image_width, output ready);
endinterface

// ===== src/rank_brightness_mapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_brightness_mapper_core
// Histogram equalization of pixel values to 8-bit brightness, with the
// histogram and the finished map held in one RAM.
// ----------------------------------------------------------------------------
// Load and map items stream back to back, one per cycle, while the block is
// idle and no map result waits on the output. A load is a read-modify-write
// of its bin, with the previous write forwarded. A map item's bin goes into
// the RAM output register, then the result register once the output is free.
// A clear item, and reset, run a sweep that zeroes the table at one bin per
// cycle unless a load write takes the port; no item is taken meanwhile. A
// finish item runs the shape check on the shared serial divider and, on the
// first good finish with a nonzero total, walks the bins from MAX_VALUE down
// to 1: RAM read, a 191x multiply, and an 8-step divide by the total. The
// finish's result beat follows the check or the walk. The width register
// may be written only while the block is idle.
// ----------------------------------------------------------------------------
module rank_brightness_mapper_core #(
	parameter int MAX_VALUE  = 4095,
	parameter int COUNT_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	rbm_cfg_if.sink      cfg,
	rbm_sample_if.sink   samples,
	rbm_result_if.source results
);
	import rbm_pkg::*;

	localparam int DEPTH = MAX_VALUE + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = COUNT_BITS;
	localparam int DW    = (CW > WIDTH_BITS) ? CW : WIDTH_BITS;
	localparam int PW    = CW + 8;
	localparam int SW    = $clog2(DW + 1);
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};
	localparam logic [AW-1:0] TOP_BIN = AW'(MAX_VALUE);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_CHKW = 4'd3;
	localparam logic [3:0] ST_WRD  = 4'd4;
	localparam logic [3:0] ST_WMUL = 4'd5;
	localparam logic [3:0] ST_WST  = 4'd6;
	localparam logic [3:0] ST_WDIV = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]            st_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [CW-1:0]         sample_q;
	logic [CW-1:0]         total_q;
	logic                  map_rdy_q;
	logic                  ok_q;
	logic [AW-1:0]         addr_q;
	logic [CW-1:0]         remain_q;
	logic [CW-1:0]         here_q;
	logic [PW-1:0]         prod_q;

	logic                  ld_s1;
	logic                  mp_s1;
	logic [AW-1:0]         addr_s1;
	logic                  rdy_s1;
	logic                  nz_s1;

	logic                  fwd_vld_q;
	logic [AW-1:0]         fwd_addr_q;
	logic [CW-1:0]         fwd_data_q;

	logic                  res_vld_q;
	logic [BRI_W-1:0]      res_bri_q;
	logic                  res_stat_q;

	logic                  acc;
	logic                  pv_nz;
	logic [AW-1:0]         bin_in;
	logic                  out_free;
	logic                  s1_stall;
	logic [CW-1:0]         cur;
	logic [CW-1:0]         rd_data;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [CW-1:0]         wdata;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic                  quick_bad;
	logic                  div_start;
	logic [SW-1:0]         div_steps;
	logic [DW-1:0]         div_rinit;
	logic [DW-1:0]         div_num;
	logic [DW-1:0]         div_dvsr;
	logic                  div_done;
	logic [DW-1:0]         div_rem;
	logic [DW-1:0]         div_quot;
	logic [BRI_W-1:0]      bri_new;

	assign cfg.ready = 1'b1;

	assign acc    = samples.valid && samples.ready;
	assign pv_nz  = samples.pixel_value != '0;
	assign bin_in = (32'(samples.pixel_value) > 32'(MAX_VALUE)) ? TOP_BIN
	                                                             : AW'(samples.pixel_value);

	assign out_free      = !res_vld_q || results.ready;
	assign s1_stall      = mp_s1 && !out_free;
	assign samples.ready = (st_q == ST_IDLE) && !s1_stall;

	// value of the bin read for the load in stage 1, with the last write forwarded
	assign cur = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;

	assign quick_bad = (width_q == '0) || (sample_q == '0) ||
	                   (DW'(sample_q) < DW'(width_q));

	assign bri_new = BRI_W'(BRI_BASE) + div_quot[BRI_W-1:0];

	// ram ports
	assign re    = (acc && (samples.kind == KIND_LOAD || samples.kind == KIND_MAP)) ||
	               (st_q == ST_WRD);
	assign raddr = (st_q == ST_WRD) ? addr_q : bin_in;

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		if (ld_s1) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = (cur == CMAX) ? cur : cur + 1'b1;
		end else if (st_q == ST_CLR) begin
			we = 1'b1;
		end else if (st_q == ST_WDIV && div_done) begin
			we    = 1'b1;
			wdata = CW'(bri_new);
		end
	end

	// divider shared by the shape check and the walk
	always_comb begin
		div_start = 1'b0;
		div_steps = SW'(DW);
		div_rinit = '0;
		div_num   = DW'(sample_q);
		div_dvsr  = DW'(width_q);
		if (st_q == ST_CHK) begin
			div_start = !quick_bad;
		end else if (st_q == ST_WST) begin
			div_start = 1'b1;
			div_steps = SW'(8);
			div_rinit = DW'(prod_q[PW-1:8]);
			div_num   = {prod_q[7:0], {(DW-8){1'b0}}};
			div_dvsr  = DW'(total_q);
		end
	end

	rbm_ram #(.W(CW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	rbm_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.rem_init (div_rinit),
		.num      (div_num),
		.divisor  (div_dvsr),
		.done     (div_done),
		.rem      (div_rem),
		.quot     (div_quot)
	);

	// control: counters, sweep, shape check and walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLR;
			addr_q    <= '0;
			width_q   <= WIDTH_BITS'(1);
			sample_q  <= '0;
			total_q   <= '0;
			map_rdy_q <= 1'b0;
			ok_q      <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				width_q <= cfg.image_width;
			if (acc) begin
				unique case (samples.kind)
					KIND_CLEAR: begin
						sample_q  <= '0;
						total_q   <= '0;
						map_rdy_q <= 1'b0;
					end
					KIND_LOAD: begin
						if (!map_rdy_q) begin
							if (sample_q != CMAX)
								sample_q <= sample_q + 1'b1;
							if (pv_nz && total_q != CMAX)
								total_q <= total_q + 1'b1;
						end
					end
					KIND_FINISH, KIND_MAP: ;
				endcase
			end
			unique case (st_q)
				ST_IDLE: begin
					if (acc && samples.kind == KIND_CLEAR) begin
						st_q   <= ST_CLR;
						addr_q <= '0;
					end else if (acc && samples.kind == KIND_FINISH) begin
						st_q <= ST_CHK;
					end
				end
				ST_CLR: begin
					// a load write in stage 1 takes the port first
					if (!ld_s1) begin
						if (addr_q == TOP_BIN)
							st_q <= ST_IDLE;
						else
							addr_q <= addr_q + 1'b1;
					end
				end
				ST_CHK: begin
					if (quick_bad) begin
						ok_q <= 1'b0;
						st_q <= ST_FIN;
					end else begin
						st_q <= ST_CHKW;
					end
				end
				ST_CHKW: begin
					if (div_done) begin
						ok_q <= (div_rem == '0);
						st_q <= ST_FIN;
						if (div_rem == '0 && !map_rdy_q) begin
							if (total_q == '0) begin
								map_rdy_q <= 1'b1;
							end else begin
								remain_q <= total_q;
								addr_q   <= TOP_BIN;
								st_q     <= ST_WRD;
							end
						end
					end
				end
				ST_WRD: st_q <= ST_WMUL;
				ST_WMUL: begin
					here_q <= rd_data;
					prod_q <= PW'(remain_q) * PW'(BRI_SPAN);
					st_q   <= ST_WST;
				end
				ST_WST: st_q <= ST_WDIV;
				ST_WDIV: begin
					if (div_done) begin
						remain_q <= (here_q > remain_q) ? '0 : remain_q - here_q;
						if (addr_q == AW'(1)) begin
							map_rdy_q <= 1'b1;
							st_q      <= ST_FIN;
						end else begin
							addr_q <= addr_q - 1'b1;
							st_q   <= ST_WRD;
						end
					end
				end
				ST_FIN: begin
					if (!mp_s1 && out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// stage 1: bin data back from the ram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s1     <= 1'b0;
			mp_s1     <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= we;
			if (!s1_stall) begin
				ld_s1 <= acc && samples.kind == KIND_LOAD && !map_rdy_q && pv_nz;
				mp_s1 <= acc && samples.kind == KIND_MAP;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
		if (acc) begin
			addr_s1 <= bin_in;
			rdy_s1  <= map_rdy_q;
			nz_s1   <= pv_nz;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (mp_s1 && out_free) begin
			res_vld_q <= 1'b1;
		end else if (st_q == ST_FIN && out_free) begin
			res_vld_q <= 1'b1;
		end else if (results.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mp_s1 && out_free) begin
			res_bri_q  <= (rdy_s1 && nz_s1) ? rd_data[BRI_W-1:0] : '0;
			res_stat_q <= !rdy_s1;
		end else if (st_q == ST_FIN && out_free) begin
			res_bri_q  <= '0;
			res_stat_q <= !ok_q;
		end
	end

	assign results.valid      = res_vld_q;
	assign results.brightness = res_bri_q;
	assign results.status     = res_stat_q;

	a_bad_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status |-> results.brightness == '0)
		else $error("result with bad status carries nonzero brightness");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WDIV && div_done |-> div_quot <= DW'(BRI_SPAN))
		else $error("walk quotient out of range");

	a_remain_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WMUL || st_q == ST_WST || st_q == ST_WDIV) |-> remain_q <= total_q)
		else $error("remaining count exceeds total during walk");

	a_map_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(map_rdy_q) |-> $past(st_q) == ST_WDIV || $past(st_q) == ST_CHKW)
		else $error("map ready set outside a finish");

endmodule

// ===== src/rbm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rbm_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== src/rbm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_div
// Restoring divider, one quotient bit per cycle. The remainder starts at
// rem_init and the top bits of num are shifted in, steps of them.
// ----------------------------------------------------------------------------
module rbm_div #(
	parameter int W     = 24,
	localparam int SW   = $clog2(W + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [SW-1:0] steps,
	input  logic [W-1:0]  rem_init,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  divisor,
	output logic          done,
	output logic [W-1:0]  rem,
	output logic [W-1:0]  quot
);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  num_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  div_q;
	logic [W:0]    trial;
	logic          ge;

	assign trial = {rem_q, num_q[W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= num;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits W bits
			rem_q  <= ge ? W'(trial - {1'b0, div_q}) : trial[W-1:0];
			num_q  <= {num_q[W-2:0], 1'b0};
			quot_q <= {quot_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
	assign quot = quot_q;

endmodule

// ===== tb/rank_brightness_mapper_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_brightness_mapper_core_tb
// Drives clear, load, finish and map items into the rank brightness mapper
// through its valid/ready channels and checks every result beat against a
// cycle-free model of the histogram equalization. The run starts with
// directed shape and mapping corners, then sessions of well-formed image loads
// with random content and some noise, and random stalls on both sides.
// ----------------------------------------------------------------------------
module rank_brightness_mapper_core_tb;
	import rbm_pkg::*;

	localparam int MAX_VALUE     = 4095;
	localparam int COUNT_BITS    = 24;
	localparam int RANDOM_ITEMS  = 500;
	localparam int SETTLE_CYCLES = MAX_VALUE + 1 + 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int END_CYCLES    = 100;
	localparam int QUIET_LIMIT   = 200000;
	localparam logic [PIX_W-1:0] TOP_PIX = PIX_W'(MAX_VALUE);

	typedef struct packed {
		logic [BRI_W-1:0] brightness;
		logic             status;
	} brightness_beat_t;

	// histogram state, the equalized map it turns into, and the beats owed
	class brightness_checker;
		int unsigned           bin_counts[MAX_VALUE+1];
		int unsigned           nz_total;
		int unsigned           sample_total;
		bit                    map_built;
		logic [WIDTH_BITS-1:0] width;
		brightness_beat_t      owed_beats[$];
		int                    errors;
		int                    checked;
		int                    useful_items;
		int                    maps_built;
		int                    bad_shapes;

		function new();
			clear_histogram();
			width = 1;
		endfunction

		function void clear_histogram();
			foreach (bin_counts[i]) bin_counts[i] = 0;
			nz_total = 0;
			sample_total = 0;
			map_built = 1'b0;
		endfunction

		function int unsigned sat_inc(int unsigned x);
			int unsigned top;
			top = (32'd1 << COUNT_BITS) - 1;
			return (x >= top) ? top : x + 1;
		endfunction

		function bit shape_good();
			if (width == 0 || sample_total == 0) return 1'b0;
			if (sample_total < width) return 1'b0;
			return (sample_total % width) == 0;
		endfunction

		// walk from the top bin down, counts become brightness
		function void equalize();
			longint unsigned remaining;
			int unsigned     here;
			if (nz_total == 0) return;
			remaining = nz_total;
			for (int b = MAX_VALUE; b >= 1; b--) begin
				here = bin_counts[b];
				bin_counts[b] = BRI_BASE + int'((remaining * BRI_SPAN) / nz_total);
				remaining = (here > remaining) ? 0 : remaining - here;
			end
		endfunction

		function void note_sample(logic [KIND_W-1:0] kind, logic [PIX_W-1:0] pix);
			brightness_beat_t beat;
			int unsigned      bin;
			bit               ok;
			bin = (pix > MAX_VALUE) ? MAX_VALUE : pix;
			useful_items++;
			case (kind)
				KIND_CLEAR: begin
					clear_histogram();
				end
				KIND_LOAD: begin
					if (map_built) begin
						useful_items--;
					end else begin
						sample_total = sat_inc(sample_total);
						if (pix != 0) begin
							bin_counts[bin] = sat_inc(bin_counts[bin]);
							nz_total = sat_inc(nz_total);
						end
					end
				end
				KIND_FINISH: begin
					ok = shape_good();
					if (ok && !map_built) begin
						equalize();
						map_built = 1'b1;
						maps_built++;
					end
					if (!ok) bad_shapes++;
					beat.brightness = '0;
					beat.status = !ok;
					owed_beats.push_back(beat);
				end
				default: begin
					if (!map_built) begin
						beat.brightness = '0;
						beat.status = 1'b1;
					end else begin
						beat.brightness = (pix == 0) ? '0 : bin_counts[bin][BRI_W-1:0];
						beat.status = 1'b0;
					end
					owed_beats.push_back(beat);
				end
			endcase
		endfunction

		function void check_result(logic [BRI_W-1:0] brightness, logic status);
			brightness_beat_t want;
			if (owed_beats.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected: brightness %0d status %0d",
					$time, brightness, status);
				return;
			end
			want = owed_beats.pop_front();
			checked++;
			if (brightness !== want.brightness) begin
				errors++;
				$display("%0t: brightness mismatch: expected %0d, got %0d",
					$time, want.brightness, brightness);
			end
			if (status !== want.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.status, status);
			end
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rbm_cfg_if    cfg_if();
	rbm_sample_if samples_if();
	rbm_result_if results_if();

	rank_brightness_mapper_core #(
		.MAX_VALUE(MAX_VALUE),
		.COUNT_BITS(COUNT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.samples(samples_if),
		.results(results_if)
	);

	brightness_checker sb;
	bit                steady;
	bit                hold_off_req;
	logic [PIX_W-1:0]  favored[4];
	int                quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, one long hold-off on request
	always begin
		@(negedge clk);
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			results_if.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
		end
		results_if.ready <= steady || ($urandom_range(0, 99) >= 26);
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1)
			sb.check_result(results_if.brightness, results_if.status);
	end

	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat on any channel for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PIX_W-1:0] pix);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 26) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.kind <= kind;
		samples_if.pixel_value <= pix;
		do @(posedge clk); while (samples_if.ready !== 1'b1);
		sb.note_sample(kind, pix);
	endtask

	task automatic drain();
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// only written with the block idle, so let any sweep or walk finish
	task automatic write_width(input logic [WIDTH_BITS-1:0] w);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.image_width <= w;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		sb.width = w;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 15) return TOP_PIX;
		if (r < 55) return PIX_W'($urandom_range(0, 4095));
		return favored[$urandom_range(0, 3)];
	endfunction

	task automatic send_loads(input int n);
		repeat (n) send_item(KIND_LOAD, pick_pixel());
	endtask

	task automatic send_maps(input int n);
		repeat (n) send_item(KIND_MAP, pick_pixel());
	endtask

	// rows of a full image, sometimes one short first to hit a bad shape
	task automatic image_session(input logic [WIDTH_BITS-1:0] w, input bit squeeze);
		int loads;
		loads = (w >= 1 && w <= 8) ? $urandom_range(1, 4) * w : $urandom_range(1, 20);
		if (loads > 1 && $urandom_range(0, 3) == 0) begin
			send_loads(loads - 1);
			send_item(KIND_FINISH, PIX_W'($urandom_range(0, 4095)));
			send_loads(1);
		end else begin
			send_loads(loads);
		end
		send_item(KIND_FINISH, PIX_W'($urandom_range(0, 4095)));
		// wait out the walk so the hold-off lands on the map beats
		if (squeeze) begin
			drain();
			hold_off_req = 1'b1;
		end
		send_maps($urandom_range(15, 35));
		if ($urandom_range(0, 2) == 0) begin
			send_loads($urandom_range(1, 3));
			send_item(KIND_FINISH, PIX_W'($urandom_range(0, 4095)));
			send_maps($urandom_range(2, 6));
		end
	endtask

	task automatic noise_burst(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 5)       send_item(KIND_CLEAR, PIX_W'($urandom_range(0, 4095)));
			else if (r < 50) send_item(KIND_LOAD, pick_pixel());
			else if (r < 65) send_item(KIND_FINISH, PIX_W'($urandom_range(0, 4095)));
			else             send_item(KIND_MAP, pick_pixel());
		end
	endtask

	initial begin
		int                    start_items;
		int                    session;
		logic [WIDTH_BITS-1:0] w;
		sb = new();
		steady = 1'b0;
		hold_off_req = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.image_width = '0;
		samples_if.valid = 1'b0;
		samples_if.kind = KIND_CLEAR;
		samples_if.pixel_value = '0;
		results_if.ready = 1'b0;
		favored[0] = 12'd1;
		favored[1] = 12'd2048;
		favored[2] = 12'hAAA;
		favored[3] = 12'h555;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// shape failures, then a real map with zero and top-bin samples
		write_width(2);
		send_item(KIND_MAP, 12'd5);
		send_item(KIND_FINISH, '0);
		send_item(KIND_LOAD, '0);
		send_item(KIND_LOAD, TOP_PIX);
		send_item(KIND_LOAD, 12'd1);
		send_item(KIND_LOAD, 12'd2048);
		send_item(KIND_LOAD, 12'hAAA);
		send_item(KIND_FINISH, 12'hFFF);
		send_item(KIND_LOAD, 12'h555);
		send_item(KIND_FINISH, '0);
		send_item(KIND_MAP, '0);
		send_item(KIND_MAP, 12'd1);
		send_item(KIND_MAP, TOP_PIX);
		send_item(KIND_MAP, 12'd3000);
		send_item(KIND_MAP, 12'h555);
		send_item(KIND_LOAD, 12'd7);
		send_item(KIND_FINISH, '0);
		send_item(KIND_MAP, 12'd7);

		// zero width is always a bad shape
		write_width(0);
		send_item(KIND_CLEAR, '0);
		send_item(KIND_LOAD, '0);
		send_item(KIND_LOAD, '0);
		send_item(KIND_FINISH, '0);
		// fewer samples than one row
		write_width(24'hFFFFFF);
		send_item(KIND_FINISH, '0);
		// good shape with only zero samples leaves everything at 0
		write_width(1);
		send_item(KIND_FINISH, '0);
		send_item(KIND_MAP, TOP_PIX);
		send_item(KIND_MAP, '0);

		start_items = sb.useful_items;
		session = 0;
		while (sb.useful_items - start_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) w = WIDTH_BITS'($urandom_range(0, 24'hFFFFFF));
			else w = WIDTH_BITS'($urandom_range(1, 8));
			write_width(w);
			steady = (session == 3);
			foreach (favored[i]) favored[i] = PIX_W'($urandom_range(1, 4095));
			send_item(KIND_CLEAR, PIX_W'($urandom_range(0, 4095)));
			if (session != 0 && $urandom_range(0, 4) == 0) noise_burst(20);
			else image_session(w, session == 0);
			session++;
		end
		steady = 1'b0;

		drain();
		repeat (END_CYCLES) @(posedge clk);
		$display("covered %0d items in %0d random sessions, %0d result beats checked",
			sb.useful_items, session, sb.checked);
		$display("built %0d maps, saw %0d bad-shape finishes", sb.maps_built, sb.bad_shapes);
		if (sb.pending() != 0)
			$display("%0t: %0d expected beats never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
